FILE: rtl/core/sepc_pkg.sv
// Shared types and pattern codes for the split event pattern classifier.
package sepc_pkg;

	localparam int ARRAY_SIDE = 1024;
	localparam int COORD_W    = $clog2(ARRAY_SIDE);
	localparam int SLOTS      = 4;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [3:0]         count_t;
	typedef logic [1:0]         slot_t;
	typedef logic [7:0]         code_t;

	typedef struct packed {
		count_t                  pixel_count;
		slot_t                   max_slot;
		slot_t                   min_slot;
		coord_t [SLOTS-1:0]      x;
		coord_t [SLOTS-1:0]      y;
	} event_t;

	typedef struct packed {
		code_t [SLOTS-1:0] code;
		logic              all_invalid;
	} result_t;

	localparam count_t COUNT_PAIR   = 4'd2;
	localparam count_t COUNT_TRIPLE = 4'd3;
	localparam count_t COUNT_QUAD   = 4'd4;

	localparam code_t INVALID_CODE_RST = 8'd255;

	// doubles: max / min
	localparam code_t D_DOWN_MAX  = 8'd15;
	localparam code_t D_DOWN_MIN  = 8'd12;
	localparam code_t D_RIGHT_MAX = 8'd25;
	localparam code_t D_RIGHT_MIN = 8'd26;
	localparam code_t D_UP_MAX    = 8'd35;
	localparam code_t D_UP_MIN    = 8'd38;
	localparam code_t D_LEFT_MAX  = 8'd45;
	localparam code_t D_LEFT_MIN  = 8'd44;

	// corner triples
	localparam code_t T1_MAX = 8'd55;
	localparam code_t T1_P   = 8'd56;
	localparam code_t T1_Q   = 8'd52;
	localparam code_t T2_MAX = 8'd65;
	localparam code_t T2_P   = 8'd68;
	localparam code_t T2_Q   = 8'd66;
	localparam code_t T3_MAX = 8'd75;
	localparam code_t T3_P   = 8'd74;
	localparam code_t T3_Q   = 8'd78;
	localparam code_t T4_MAX = 8'd85;
	localparam code_t T4_P   = 8'd82;
	localparam code_t T4_Q   = 8'd84;

	// 2x2 quadruples: max, min, same column as max, other
	localparam code_t Q1_MAX = 8'd95;
	localparam code_t Q1_MIN = 8'd93;
	localparam code_t Q1_COL = 8'd92;
	localparam code_t Q1_OTH = 8'd96;
	localparam code_t Q2_MAX = 8'd105;
	localparam code_t Q2_MIN = 8'd109;
	localparam code_t Q2_COL = 8'd108;
	localparam code_t Q2_OTH = 8'd106;
	localparam code_t Q3_MAX = 8'd115;
	localparam code_t Q3_MIN = 8'd117;
	localparam code_t Q3_COL = 8'd118;
	localparam code_t Q3_OTH = 8'd114;
	localparam code_t Q4_MAX = 8'd125;
	localparam code_t Q4_MIN = 8'd121;
	localparam code_t Q4_COL = 8'd122;
	localparam code_t Q4_OTH = 8'd124;

endpackage

FILE: rtl/core/sepc_classify.sv
// Combinational pattern classification of one registered split event.
module sepc_classify (
	input  sepc_pkg::event_t  ev,
	input  sepc_pkg::code_t   inv_code,
	output sepc_pkg::result_t res
);
	import sepc_pkg::*;

	localparam logic [COORD_W:0] ONE_W = {{COORD_W{1'b0}}, 1'b1};

	// p == q - 1
	function automatic logic succ(input coord_t p, input coord_t q);
		return ({1'b0, p} + ONE_W) == {1'b0, q};
	endfunction

	function automatic coord_t absdiff(input coord_t p, input coord_t q);
		return (p > q) ? (p - q) : (q - p);
	endfunction

	count_t n;
	slot_t  a, b, m0, m1;
	coord_t xa, ya, xb, yb, xm0, ym0, xm1, ym1;
	logic   bad_sel, tri_adj, hit0, hit1;
	code_t  ka, kb, km, kx, ko;
	code_t [SLOTS-1:0] c;

	assign n = ev.pixel_count;
	assign a = ev.max_slot;
	assign b = ev.min_slot;

	// lowest and highest slot that is neither max nor min
	always_comb begin
		if (a != 2'd0 && b != 2'd0)      m0 = 2'd0;
		else if (a != 2'd1 && b != 2'd1) m0 = 2'd1;
		else                             m0 = 2'd2;
		if (a != 2'd3 && b != 2'd3)      m1 = 2'd3;
		else if (a != 2'd2 && b != 2'd2) m1 = 2'd2;
		else                             m1 = 2'd1;
	end

	assign xa  = ev.x[a];
	assign ya  = ev.y[a];
	assign xb  = ev.x[b];
	assign yb  = ev.y[b];
	assign xm0 = ev.x[m0];
	assign ym0 = ev.y[m0];
	assign xm1 = ev.x[m1];
	assign ym1 = ev.y[m1];

	assign bad_sel = ({2'b00, a} >= n) || ({2'b00, b} >= n) || (a == b);

	assign tri_adj = (({1'b0, absdiff(xa, xb)} + {1'b0, absdiff(xa, xm0)}) == ONE_W) &&
		(({1'b0, absdiff(ya, yb)} + {1'b0, absdiff(ya, ym0)}) == ONE_W);

	assign hit0 = (xm0 == xa && ym0 == yb) || (ym0 == ya && xm0 == xb);
	assign hit1 = (xm1 == xa && ym1 == yb) || (ym1 == ya && xm1 == xb);

	// triple orientation: max, middle, min
	always_comb begin
		ka = inv_code;
		km = inv_code;
		kb = inv_code;
		if (succ(xa, xm0) && succ(ya, yb)) begin
			ka = T1_MAX; km = T1_P; kb = T1_Q;
		end else if (succ(xa, xb) && succ(ya, ym0)) begin
			ka = T1_MAX; km = T1_Q; kb = T1_P;
		end else if (succ(xa, xb) && succ(ym0, ya)) begin
			ka = T2_MAX; km = T2_P; kb = T2_Q;
		end else if (succ(xa, xm0) && succ(yb, ya)) begin
			ka = T2_MAX; km = T2_Q; kb = T2_P;
		end else if (succ(xm0, xa) && succ(yb, ya)) begin
			ka = T3_MAX; km = T3_P; kb = T3_Q;
		end else if (succ(xb, xa) && succ(ym0, ya)) begin
			ka = T3_MAX; km = T3_Q; kb = T3_P;
		end else if (succ(xb, xa) && succ(ya, ym0)) begin
			ka = T4_MAX; km = T4_P; kb = T4_Q;
		end else if (succ(xm0, xa) && succ(ya, yb)) begin
			ka = T4_MAX; km = T4_Q; kb = T4_P;
		end
	end

	// quadruple orientation: max, min, column partner, other
	logic quad_ok;
	code_t qa, qb;
	always_comb begin
		quad_ok = 1'b1;
		qa = inv_code;
		qb = inv_code;
		kx = inv_code;
		ko = inv_code;
		if (succ(xa, xb) && succ(ya, yb)) begin
			qa = Q1_MAX; qb = Q1_MIN; kx = Q1_COL; ko = Q1_OTH;
		end else if (succ(xa, xb) && succ(yb, ya)) begin
			qa = Q2_MAX; qb = Q2_MIN; kx = Q2_COL; ko = Q2_OTH;
		end else if (succ(xb, xa) && succ(yb, ya)) begin
			qa = Q3_MAX; qb = Q3_MIN; kx = Q3_COL; ko = Q3_OTH;
		end else if (succ(xb, xa) && succ(ya, yb)) begin
			qa = Q4_MAX; qb = Q4_MIN; kx = Q4_COL; ko = Q4_OTH;
		end else begin
			quad_ok = 1'b0;
		end
	end

	always_comb begin
		c = '0;
		res.all_invalid = 1'b0;
		if (n > COUNT_QUAD) begin
			c = {SLOTS{inv_code}};
			res.all_invalid = 1'b1;
		end else if (n >= COUNT_PAIR) begin
			if (bad_sel) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (count_t'(i) < n) c[i] = inv_code;
				end
			end else if (n == COUNT_PAIR) begin
				if (xa == xb && succ(ya, yb)) begin
					c[a] = D_DOWN_MAX; c[b] = D_DOWN_MIN;
				end else if (succ(xa, xb) && ya == yb) begin
					c[a] = D_RIGHT_MAX; c[b] = D_RIGHT_MIN;
				end else if (xa == xb && succ(yb, ya)) begin
					c[a] = D_UP_MAX; c[b] = D_UP_MIN;
				end else if (succ(xb, xa) && ya == yb) begin
					c[a] = D_LEFT_MAX; c[b] = D_LEFT_MIN;
				end else begin
					c[a] = inv_code; c[b] = inv_code;
				end
			end else if (n == COUNT_TRIPLE) begin
				if (tri_adj) begin
					c[a] = ka; c[m0] = km; c[b] = kb;
				end else begin
					c[a] = inv_code; c[m0] = inv_code; c[b] = inv_code;
				end
			end else begin
				if (!(hit0 && hit1) || !quad_ok) begin
					c = {SLOTS{inv_code}};
				end else begin
					c[a] = qa;
					c[b] = qb;
					if (xa == xm0) begin
						c[m0] = kx; c[m1] = ko;
					end else begin
						c[m0] = ko; c[m1] = kx;
					end
				end
			end
		end
		res.code = c;
	end

endmodule

FILE: rtl/core/split_event_pattern_classifier.sv
// Top level of the split event pattern classifier: handshake, pipeline and register.
//
// Input channel: in_valid with pixel_count, max_slot, min_slot and the four
// coordinate pairs; the block raises in_stall when it cannot take the item.
// Output channel: out_valid with code_0..code_3 and all_invalid; the receiver
// raises out_stall to hold the result in place.
// Configuration: cfg_valid/cfg_ready write invalid_code, the code given to the
// pixels of invalid shapes. cfg_ready is always high; write it only while no
// item is in flight.
// An accepted item is classified combinationally from the input register and
// stored in the result register, which drives the outputs, once it can move.
// Throughput: one item per cycle while out_stall is low, set by the input register
// and the result register with the classification compares between them.
// Reset: both stages empty, invalid_code returns to 255.
// When the receiver stalls, the result holds and one more item can still be
// taken into the input register; after that in_stall rises until the output
// drains.
module split_event_pattern_classifier (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  sepc_pkg::count_t pixel_count,
	input  sepc_pkg::slot_t  max_slot,
	input  sepc_pkg::slot_t  min_slot,
	input  sepc_pkg::coord_t x_0,
	input  sepc_pkg::coord_t y_0,
	input  sepc_pkg::coord_t x_1,
	input  sepc_pkg::coord_t y_1,
	input  sepc_pkg::coord_t x_2,
	input  sepc_pkg::coord_t y_2,
	input  sepc_pkg::coord_t x_3,
	input  sepc_pkg::coord_t y_3,
	output logic             out_valid,
	input  logic             out_stall,
	output sepc_pkg::code_t  code_0,
	output sepc_pkg::code_t  code_1,
	output sepc_pkg::code_t  code_2,
	output sepc_pkg::code_t  code_3,
	output logic             all_invalid,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  sepc_pkg::code_t  invalid_code
);
	import sepc_pkg::*;

	event_t  ev_s1;
	logic    valid_s1;
	result_t res_c;
	result_t res_s2;
	logic    valid_s2;
	code_t   invalid_code_q;
	logic    adv_s2;
	logic    take_s1;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign take_s1  = !valid_s1 || adv_s2;
	assign in_stall = valid_s1 && !adv_s2;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			invalid_code_q <= INVALID_CODE_RST;
		end else begin
			if (take_s1) valid_s1 <= in_valid;
			if (adv_s2)  valid_s2 <= valid_s1;
			if (cfg_valid) invalid_code_q <= invalid_code;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && take_s1) begin
			ev_s1.pixel_count <= pixel_count;
			ev_s1.max_slot    <= max_slot;
			ev_s1.min_slot    <= min_slot;
			ev_s1.x           <= {x_3, x_2, x_1, x_0};
			ev_s1.y           <= {y_3, y_2, y_1, y_0};
		end
		// hold the result while the receiver stalls
		if (valid_s1 && adv_s2) res_s2 <= res_c;
	end

	sepc_classify u_classify (
		.ev       (ev_s1),
		.inv_code (invalid_code_q),
		.res      (res_c)
	);

	assign out_valid   = valid_s2;
	assign code_0      = res_s2.code[0];
	assign code_1      = res_s2.code[1];
	assign code_2      = res_s2.code[2];
	assign code_3      = res_s2.code[3];
	assign all_invalid = res_s2.all_invalid;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while the output stage can move");

	a_large_event_uniform: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && all_invalid) |->
			(code_0 == code_1 && code_1 == code_2 && code_2 == code_3))
		else $error("large event with differing slot codes");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |=> (invalid_code_q == $past(invalid_code)))
		else $error("invalid code register not updated by write");

endmodule

FILE: test/split_event_pattern_classifier_tb.sv
// Self-checking testbench for the split event pattern classifier: directed table, random shapes.
module split_event_pattern_classifier_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sepc_pkg::*;

	localparam int    PHASE_ITEMS = 125;
	localparam int    CYCLE_LIMIT = 200000;
	localparam int    DRAIN_PAUSE = 4;
	localparam code_t UNUSED_CODE = 8'd0;

	// results readable straight off the rules while the reset invalid code is in force
	localparam result_t ALL_UNUSED = '0;
	localparam result_t LARGE_EVENT = {{SLOTS{INVALID_CODE_RST}}, 1'b1};
	localparam result_t BAD_PAIR = {UNUSED_CODE, UNUSED_CODE, {2{INVALID_CODE_RST}}, 1'b0};
	localparam result_t BAD_TRIPLE = {UNUSED_CODE, {3{INVALID_CODE_RST}}, 1'b0};
	localparam result_t BAD_QUAD = {{SLOTS{INVALID_CODE_RST}}, 1'b0};

	typedef struct {
		event_t  ev;
		bit      typed;
		result_t want;
	} stim_row_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_stall;
	count_t pixel_count = '0;
	slot_t  max_slot = '0;
	slot_t  min_slot = '0;
	coord_t x_0 = '0, y_0 = '0, x_1 = '0, y_1 = '0;
	coord_t x_2 = '0, y_2 = '0, x_3 = '0, y_3 = '0;
	logic   out_valid;
	logic   out_stall = 1'b0;
	code_t  code_0, code_1, code_2, code_3;
	logic   all_invalid;
	logic   cfg_valid = 1'b0;
	logic   cfg_ready;
	code_t  cfg_code = '0;

	code_t     invalid_now = INVALID_CODE_RST;
	result_t   expected_results[$];
	stim_row_t directed_rows[$];
	int        mismatch_count = 0;
	int        cycle_count = 0;
	bit        send_calm = 1'b0;
	bit        sink_calm = 1'b0;

	split_event_pattern_classifier dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_count(pixel_count),
		.max_slot(max_slot),
		.min_slot(min_slot),
		.x_0(x_0),
		.y_0(y_0),
		.x_1(x_1),
		.y_1(y_1),
		.x_2(x_2),
		.y_2(y_2),
		.x_3(x_3),
		.y_3(y_3),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.code_0(code_0),
		.code_1(code_1),
		.code_2(code_2),
		.code_3(code_3),
		.all_invalid(all_invalid),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.invalid_code(cfg_code)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("split_event_pattern_classifier test failed");
			$finish;
		end
	end

	function automatic int abs_gap(input int p, input int q);
		return (p > q) ? p - q : q - p;
	endfunction

	function automatic result_t classify_event(input event_t ev, input code_t inv);
		result_t r;
		int      n, a, b, m, m0, m1, hits, mx;
		int      xs[SLOTS];
		int      ys[SLOTS];
		code_t   ka, km, kb, kx, ko;
		bit      ok;
		r = '0;
		n = int'(ev.pixel_count);
		a = int'(ev.max_slot);
		b = int'(ev.min_slot);
		for (int i = 0; i < SLOTS; i++) begin
			xs[i] = int'(ev.x[i]);
			ys[i] = int'(ev.y[i]);
		end
		if (n > COUNT_QUAD) begin
			r.code = {SLOTS{inv}};
			r.all_invalid = 1'b1;
		end else if (n >= COUNT_PAIR) begin
			if (a >= n || b >= n || a == b) begin
				for (int i = 0; i < n; i++)
					r.code[i] = inv;
			end else if (n == COUNT_PAIR) begin
				ka = inv;
				kb = inv;
				if (xs[a] == xs[b] && ys[a] == ys[b] - 1) begin
					ka = D_DOWN_MAX;
					kb = D_DOWN_MIN;
				end else if (xs[a] == xs[b] - 1 && ys[a] == ys[b]) begin
					ka = D_RIGHT_MAX;
					kb = D_RIGHT_MIN;
				end else if (xs[a] == xs[b] && ys[a] == ys[b] + 1) begin
					ka = D_UP_MAX;
					kb = D_UP_MIN;
				end else if (xs[a] == xs[b] + 1 && ys[a] == ys[b]) begin
					ka = D_LEFT_MAX;
					kb = D_LEFT_MIN;
				end
				r.code[a] = ka;
				r.code[b] = kb;
			end else if (n == COUNT_TRIPLE) begin
				m = 0;
				while (m == a || m == b)
					m++;
				ka = inv;
				km = inv;
				kb = inv;
				if (abs_gap(xs[a], xs[b]) + abs_gap(xs[a], xs[m]) == 1 &&
				    abs_gap(ys[a], ys[b]) + abs_gap(ys[a], ys[m]) == 1) begin
					if (xs[a] == xs[m] - 1 && ys[a] == ys[b] - 1) begin
						ka = T1_MAX; km = T1_P; kb = T1_Q;
					end else if (xs[a] == xs[b] - 1 && ys[a] == ys[m] - 1) begin
						ka = T1_MAX; km = T1_Q; kb = T1_P;
					end else if (xs[a] == xs[b] - 1 && ys[a] == ys[m] + 1) begin
						ka = T2_MAX; km = T2_P; kb = T2_Q;
					end else if (xs[a] == xs[m] - 1 && ys[a] == ys[b] + 1) begin
						ka = T2_MAX; km = T2_Q; kb = T2_P;
					end else if (xs[a] == xs[m] + 1 && ys[a] == ys[b] + 1) begin
						ka = T3_MAX; km = T3_P; kb = T3_Q;
					end else if (xs[a] == xs[b] + 1 && ys[a] == ys[m] + 1) begin
						ka = T3_MAX; km = T3_Q; kb = T3_P;
					end else if (xs[a] == xs[b] + 1 && ys[a] == ys[m] - 1) begin
						ka = T4_MAX; km = T4_P; kb = T4_Q;
					end else if (xs[a] == xs[m] + 1 && ys[a] == ys[b] - 1) begin
						ka = T4_MAX; km = T4_Q; kb = T4_P;
					end
				end
				r.code[a] = ka;
				r.code[m] = km;
				r.code[b] = kb;
			end else begin
				// middle slots in ascending order
				m0 = -1;
				m1 = -1;
				for (int i = 0; i < SLOTS; i++)
					if (i != a && i != b) begin
						if (m0 < 0)
							m0 = i;
						else
							m1 = i;
					end
				hits = 0;
				for (int k = 0; k < 2; k++) begin
					mx = (k == 0) ? m0 : m1;
					if ((xs[mx] == xs[a] && ys[mx] == ys[b]) ||
					    (ys[mx] == ys[a] && xs[mx] == xs[b]))
						hits++;
				end
				ok = 1'b0;
				ka = inv; kb = inv; kx = inv; ko = inv;
				if (hits == 2) begin
					ok = 1'b1;
					if (xs[a] == xs[b] - 1 && ys[a] == ys[b] - 1) begin
						ka = Q1_MAX; kb = Q1_MIN; kx = Q1_COL; ko = Q1_OTH;
					end else if (xs[a] == xs[b] - 1 && ys[a] == ys[b] + 1) begin
						ka = Q2_MAX; kb = Q2_MIN; kx = Q2_COL; ko = Q2_OTH;
					end else if (xs[a] == xs[b] + 1 && ys[a] == ys[b] + 1) begin
						ka = Q3_MAX; kb = Q3_MIN; kx = Q3_COL; ko = Q3_OTH;
					end else if (xs[a] == xs[b] + 1 && ys[a] == ys[b] - 1) begin
						ka = Q4_MAX; kb = Q4_MIN; kx = Q4_COL; ko = Q4_OTH;
					end else begin
						ok = 1'b0;
					end
				end
				if (ok) begin
					r.code[a] = ka;
					r.code[b] = kb;
					if (xs[a] == xs[m0]) begin
						r.code[m0] = kx;
						r.code[m1] = ko;
					end else begin
						r.code[m0] = ko;
						r.code[m1] = kx;
					end
				end else begin
					r.code = {SLOTS{inv}};
				end
			end
		end
		return r;
	endfunction

	function automatic void add_row(input int n, input int a, input int b,
			input int x0, input int y0, input int x1, input int y1,
			input int x2, input int y2, input int x3, input int y3,
			input bit typed = 1'b0, input result_t want = '0);
		stim_row_t row;
		row.ev.pixel_count = count_t'(n);
		row.ev.max_slot = slot_t'(a);
		row.ev.min_slot = slot_t'(b);
		row.ev.x[0] = coord_t'(x0);
		row.ev.y[0] = coord_t'(y0);
		row.ev.x[1] = coord_t'(x1);
		row.ev.y[1] = coord_t'(y1);
		row.ev.x[2] = coord_t'(x2);
		row.ev.y[2] = coord_t'(y2);
		row.ev.x[3] = coord_t'(x3);
		row.ev.y[3] = coord_t'(y3);
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endfunction

	// Pairs to quads: build a well-formed shape around a random anchor, then now and then spoil it.
	task automatic make_event(output event_t ev);
		int n, bx, by, sx, sy, pick, k, tmp;
		int px[SLOTS];
		int py[SLOTS];
		int perm[SLOTS];
		for (int i = 0; i < SLOTS; i++) begin
			ev.x[i] = coord_t'($urandom_range(0, ARRAY_SIDE - 1));
			ev.y[i] = coord_t'($urandom_range(0, ARRAY_SIDE - 1));
			perm[i] = i;
		end
		pick = $urandom_range(0, 99);
		if (pick < 3)
			n = 0;
		else if (pick < 10)
			n = 1;
		else if (pick < 32)
			n = COUNT_PAIR;
		else if (pick < 60)
			n = COUNT_TRIPLE;
		else if (pick < 88)
			n = COUNT_QUAD;
		else
			n = $urandom_range(COUNT_QUAD + 1, 15);
		ev.pixel_count = count_t'(n);
		ev.max_slot = slot_t'($urandom_range(0, SLOTS - 1));
		ev.min_slot = slot_t'($urandom_range(0, SLOTS - 1));
		if (n >= COUNT_PAIR && n <= COUNT_QUAD) begin
			// bias the anchor towards the array edges
			if ($urandom_range(0, 7) == 0) begin
				bx = $urandom_range(0, 1) ? $urandom_range(0, 1) :
					$urandom_range(ARRAY_SIDE - 2, ARRAY_SIDE - 1);
				by = $urandom_range(0, 1) ? $urandom_range(0, 1) :
					$urandom_range(ARRAY_SIDE - 2, ARRAY_SIDE - 1);
			end else begin
				bx = $urandom_range(0, ARRAY_SIDE - 1);
				by = $urandom_range(0, ARRAY_SIDE - 1);
			end
			sx = $urandom_range(0, 1) ? 1 : -1;
			sy = $urandom_range(0, 1) ? 1 : -1;
			px[0] = bx;
			py[0] = by;
			case (count_t'(n))
				COUNT_PAIR: begin
					if ($urandom_range(0, 1)) begin
						px[1] = bx + sx;
						py[1] = by;
					end else begin
						px[1] = bx;
						py[1] = by + sy;
					end
				end
				COUNT_TRIPLE: begin
					px[1] = bx + sx;
					py[1] = by;
					px[2] = bx;
					py[2] = by + sy;
					if ($urandom_range(0, 1)) begin
						px[1] = bx;
						py[1] = by + sy;
						px[2] = bx + sx;
						py[2] = by;
					end
				end
				default: begin
					px[1] = bx + sx;
					py[1] = by + sy;
					px[2] = bx + sx;
					py[2] = by;
					px[3] = bx;
					py[3] = by + sy;
				end
			endcase
			for (int i = n - 1; i > 0; i--) begin
				k = $urandom_range(0, i);
				tmp = perm[i];
				perm[i] = perm[k];
				perm[k] = tmp;
			end
			for (int i = 0; i < n; i++) begin
				ev.x[perm[i]] = coord_t'(px[i]);
				ev.y[perm[i]] = coord_t'(py[i]);
			end
			ev.max_slot = slot_t'(perm[0]);
			ev.min_slot = slot_t'(perm[1]);
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				ev.max_slot = slot_t'($urandom_range(0, SLOTS - 1));
				ev.min_slot = slot_t'($urandom_range(0, SLOTS - 1));
			end else if (pick < 14) begin
				k = $urandom_range(0, n - 1);
				if ($urandom_range(0, 1))
					ev.x[k] = coord_t'(int'(ev.x[k]) + ($urandom_range(0, 1) ? 1 : -1));
				else
					ev.y[k] = coord_t'(int'(ev.y[k]) + ($urandom_range(0, 1) ? 1 : -1));
			end
		end
	endtask

	task automatic send_event(input event_t ev, input bit typed, input result_t want);
		int gap;
		if ($urandom_range(0, 29) == 0)
			send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_count <= ev.pixel_count;
		max_slot <= ev.max_slot;
		min_slot <= ev.min_slot;
		x_0 <= ev.x[0];
		y_0 <= ev.y[0];
		x_1 <= ev.x[1];
		y_1 <= ev.y[1];
		x_2 <= ev.x[2];
		y_2 <= ev.y[2];
		x_3 <= ev.x[3];
		y_3 <= ev.y[3];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_results.push_back(typed ? want : classify_event(ev, invalid_now));
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_invalid_code(input code_t value);
		cfg_valid <= 1'b1;
		cfg_code <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		invalid_now = value;
	endtask

	// Receiver: hold stall for a drawn number of cycles, then take one item.
	initial begin : result_sink
		int hold;
		while (!arst_n)
			@(posedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0)
				sink_calm = !sink_calm;
			hold = sink_calm ? 0 : $urandom_range(0, 16);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		code_t   seen[SLOTS];
		if (arst_n && out_valid && !out_stall) begin
			seen[0] = code_0;
			seen[1] = code_1;
			seen[2] = code_2;
			seen[3] = code_3;
			if (expected_results.size() == 0) begin
				$error("result with no item outstanding: code_0 %0d all_invalid %0d",
					code_0, all_invalid);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				for (int i = 0; i < SLOTS; i++)
					if (seen[i] !== want.code[i]) begin
						$error("code_%0d: expected %0d, actual %0d", i, want.code[i], seen[i]);
						mismatch_count++;
					end
				if (all_invalid !== want.all_invalid) begin
					$error("all_invalid: expected %0d, actual %0d", want.all_invalid,
						all_invalid);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : stimulus
		event_t ev;
		code_t  phase_codes[6];
		phase_codes[0] = 8'd0;
		phase_codes[1] = 8'd255;
		phase_codes[2] = code_t'($urandom_range(1, 254));
		phase_codes[3] = 8'd128;
		phase_codes[4] = code_t'($urandom_range(1, 254));
		phase_codes[5] = 8'd1;

		// empty, single and large events, bad selectors
		add_row(0, 3, 3, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1'b1, ALL_UNUSED);
		add_row(1, 3, 0, 1023, 0, 0, 1023, 0, 0, 0, 0, 1'b1, ALL_UNUSED);
		add_row(9, 0, 0, 5, 5, 5, 6, 6, 5, 6, 6, 1'b1, LARGE_EVENT);
		add_row(15, 1, 2, 1023, 0, 0, 1023, 512, 511, 1, 1022, 1'b1, LARGE_EVENT);
		add_row(5, 2, 3, 0, 0, 0, 1, 1, 0, 1, 1, 1'b1, LARGE_EVENT);
		add_row(2, 0, 0, 5, 5, 5, 6, 0, 0, 0, 0, 1'b1, BAD_PAIR);
		add_row(3, 3, 0, 10, 10, 11, 10, 10, 11, 0, 0, 1'b1, BAD_TRIPLE);
		add_row(4, 1, 1, 0, 0, 0, 1, 1, 0, 1, 1, 1'b1, BAD_QUAD);
		// doubles in all four directions, and a wrapped non-neighbour
		add_row(2, 0, 1, 5, 5, 5, 6, 0, 0, 0, 0);
		add_row(2, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0);
		add_row(2, 0, 1, 1023, 1023, 1023, 1022, 0, 0, 0, 0);
		add_row(2, 0, 1, 1, 7, 0, 7, 0, 0, 0, 0);
		add_row(2, 0, 1, 0, 0, 1023, 1023, 0, 0, 0, 0);
		// corner triples, a straight line and a coincident one
		add_row(3, 0, 2, 10, 10, 11, 10, 10, 11, 0, 0);
		add_row(3, 2, 0, 11, 10, 10, 11, 10, 10, 0, 0);
		add_row(3, 1, 0, 21, 20, 20, 20, 20, 19, 0, 0);
		add_row(3, 0, 1, 1, 1, 1, 0, 0, 1, 0, 0);
		add_row(3, 2, 1, 1023, 1, 1022, 0, 1023, 0, 0, 0);
		add_row(3, 0, 2, 5, 5, 6, 5, 7, 5, 0, 0);
		add_row(3, 0, 1, 3, 3, 3, 3, 3, 3, 0, 0);
		// 2x2 quadruples in all four orientations, and a coincident one
		add_row(4, 0, 3, 100, 100, 100, 101, 101, 100, 101, 101);
		add_row(4, 3, 0, 0, 0, 0, 1, 1, 0, 1, 1);
		add_row(4, 1, 2, 501, 501, 500, 501, 501, 500, 500, 500);
		add_row(4, 2, 1, 7, 8, 6, 8, 7, 7, 6, 7);
		add_row(4, 0, 1, 9, 9, 9, 9, 9, 9, 9, 9);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);

		foreach (phase_codes[p]) begin
			drain();
			write_invalid_code(phase_codes[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				make_event(ev);
				send_event(ev, 1'b0, '0);
			end
		end

		drain();
		repeat (DRAIN_PAUSE) @(posedge clk);
		if (mismatch_count == 0)
			$display("split_event_pattern_classifier test passed");
		else
			$display("split_event_pattern_classifier test failed");
		$finish;
	end

endmodule
